[hdl/assert_macros.svh]
// assertion macros used by the top level of the list core rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/ilie_pkg.sv]
// types, codes and sizing constants for the indexed list core
// no dependencies; imported by every module of the core
package ilie_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        REQ_READ        = 3'd0,
        REQ_WRITE       = 3'd1,
        REQ_APPEND      = 3'd2,
        REQ_REMOVE_LAST = 3'd3,
        REQ_INSERT      = 3'd4,
        REQ_ERASE       = 3'd5
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t                 req_type;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  element_value;
    } req_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  read_value;
        logic [6:0]                element_count;
        status_t                   status;
    } rsp_beat_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_INSERT = 2'd2,
        OP_ERASE  = 2'd3
    } cell_op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t                  op;
        logic [IDX_W-1:0]          target;
        logic [DATA_W-1:0]         value;
        logic                      read_en;
    } cell_cmd_t;

endpackage

[hdl/ilie_cell.sv]
// one storage cell of the list chain: holds a word, shifts to/from neighbors
// depends on ilie_pkg
module ilie_cell (
    input  logic                          clk,
    input  logic [ilie_pkg::IDX_W-1:0]    idx,
    input  ilie_pkg::cell_cmd_t           cmd,
    input  logic [ilie_pkg::DATA_W-1:0]   left_data,
    input  logic [ilie_pkg::DATA_W-1:0]   right_data,
    output logic [ilie_pkg::DATA_W-1:0]   data,
    output logic [ilie_pkg::DATA_W-1:0]   rd_data
);
    import ilie_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit;

    assign hit = (idx == cmd.target);

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            OP_HOLD:
            begin
                data_next = data_reg;
            end
            OP_LOAD:
            begin
                if (hit)
                begin
                    data_next = cmd.value;
                end
            end
            OP_INSERT:
            begin
                // cells above the slot take their lower neighbor
                if (idx > cmd.target)
                begin
                    data_next = left_data;
                end
                else if (hit)
                begin
                    data_next = cmd.value;
                end
            end
            OP_ERASE:
            begin
                if (idx >= cmd.target)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (cmd.read_en && hit) ? data_reg : '0;

endmodule

[hdl/ilie_ctrl.sv]
// request decode, bounds checks and element count register
// depends on ilie_pkg
module ilie_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  ilie_pkg::req_beat_t         req,
    output ilie_pkg::cell_cmd_t         cmd,
    output ilie_pkg::status_t           status,
    output logic [ilie_pkg::CNT_W-1:0]  count_next,
    output logic [ilie_pkg::CNT_W-1:0]  count
);
    import ilie_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic             full;

    assign pos_c = CMP_W'(req.position);
    assign cnt_c = CMP_W'(count_reg);
    assign full  = (count_reg >= CAP_CNT);

    always_comb
    begin
        cmd.op      = OP_HOLD;
        cmd.target  = IDX_W'(req.position);
        cmd.value   = req.element_value;
        cmd.read_en = 1'b0;
        status      = STATUS_OK;
        count_next  = count_reg;
        unique case (req.req_type)
            REQ_READ:
            begin
                if (pos_c < cnt_c)
                begin
                    cmd.read_en = 1'b1;
                end
                else
                begin
                    status = STATUS_BAD;
                end
            end
            REQ_WRITE:
            begin
                if (pos_c < cnt_c)
                begin
                    cmd.op = OP_LOAD;
                end
                else
                begin
                    status = STATUS_BAD;
                end
            end
            REQ_APPEND:
            begin
                if (full)
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    cmd.op     = OP_INSERT;
                    cmd.target = IDX_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_REMOVE_LAST:
            begin
                if (count_reg == '0)
                begin
                    status = STATUS_BAD;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_INSERT:
            begin
                // full check wins over the index check
                if (full)
                begin
                    status = STATUS_FULL;
                end
                else if (pos_c > cnt_c)
                begin
                    status = STATUS_BAD;
                end
                else
                begin
                    cmd.op     = OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_ERASE:
            begin
                if (pos_c >= cnt_c)
                begin
                    status = STATUS_BAD;
                end
                else
                begin
                    cmd.op     = OP_ERASE;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status = STATUS_BAD;
            end
        endcase
        if (!accept)
        begin
            cmd.op = OP_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

[hdl/indexed_list_insert_erase_core.sv]
// top level of the fixed-capacity ordered list: controller, cell chain, result register
// depends on ilie_pkg, ilie_ctrl, ilie_cell and assert_macros.svh
//
//  channel  | direction | handshake             | beat
//  ---------+-----------+-----------------------+------------------------------------------
//  req      | in        | req_valid / req_ready | req_type, position, element_value
//  rsp      | out       | rsp_valid / rsp_ready | read_value, element_count, status
//
// one request per cycle while rsp is not stalled: every cell updates in the cycle the request beat is taken,
// and the result is registered, so it appears the cycle after acceptance
// the single result register sets the rate: req_ready is high when it is empty or
// being drained in the same cycle
// reset clears the element count and the result valid; cell contents are left as is
// a stalled rsp holds its beat and blocks the next request only while it waits
module indexed_list_insert_erase_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ilie_pkg::req_beat_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output ilie_pkg::rsp_beat_t  rsp
);
    import ilie_pkg::*;
    `include "assert_macros.svh"

    // handshake and control
    logic                 req_accept;
    logic                 rsp_valid_reg;
    rsp_beat_t            rsp_reg;
    rsp_beat_t            rsp_next;

    // controller outputs
    cell_cmd_t            cmd;
    status_t              status_next;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     count;

    // cell chain
    logic [DATA_W-1:0]    cell_data [CAPACITY];
    logic [DATA_W-1:0]    cell_rd   [CAPACITY];
    logic [DATA_W-1:0]    rd_value;

    assign req_ready  = !rsp_valid_reg || rsp_ready;
    assign req_accept = req_valid && req_ready;

    ilie_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (req_accept),
        .req        (req),
        .cmd        (cmd),
        .status     (status_next),
        .count_next (count_next),
        .count      (count)
    );

    // chain of cells: insert pulls from the lower neighbor, erase from the upper one
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_data[g-1];
        end

        // top cell has nothing above; its word is dead after an erase anyway
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_data[g+1];
        end

        ilie_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(g)),
            .cmd        (cmd),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[g]),
            .rd_data    (cell_rd[g])
        );
    end

    // each cell drives zero unless it is the addressed one on a good read
    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_value = rd_value | cell_rd[i];
        end
    end

    always_comb
    begin
        rsp_next.read_value    = rd_value;
        rsp_next.element_count = 7'(count_next);
        rsp_next.status        = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count <= CNT_W'(CAPACITY))
    `ASSERT_IMPL(a_rsp_count_tracks, clk, rst_n, rsp_valid_reg, rsp_reg.element_count == 7'(count))
    `ASSERT_NEXT(a_fail_keeps_count, clk, rst_n, req_accept && (status_next != STATUS_OK), $stable(count))
    `ASSERT_IMPL(a_read_zero_on_fail, clk, rst_n, rsp_valid_reg && (rsp_reg.status != STATUS_OK), rsp_reg.read_value == '0)

endmodule

[tb/tb_indexed_list_insert_erase_core.sv]
// self-checking testbench for indexed_list_insert_erase_core: directed table, then random phases
// depends on ilie_pkg and the core rtl; predicts result beats from its own copy of the list unless typed in the table
`timescale 1ns / 1ps

module tb_indexed_list_insert_erase_core;

    import ilie_pkg::*;

    // request codes the package does not name: the core must reject them
    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS  = 1200;
    localparam int MAX_GAP       = 12;
    localparam int TAIL_CYCLES   = 8;
    // slowest legal run, with the longest gap and stall on each of about 1300 beats, is far below this
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DIRECTED_ROWS = 23;

    // traffic mix of one random phase
    typedef enum int {
        PHASE_GROW   = 0,
        PHASE_SHRINK = 1,
        PHASE_EVEN   = 2
    } phase_mix_t;

    // one directed request; where known is set the result is typed in here
    typedef struct packed {
        logic [2:0]  code;
        logic [5:0]  pos;
        logic [31:0] value;
        bit          known;
        logic [31:0] exp_value;
        logic [6:0]  exp_count;
        status_t     exp_status;
    } list_row_t;

    list_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty list: every access is rejected
        '{REQ_READ,        6'd0,  32'h0000_0000, 1'b1, 32'h0, 7'd0, STATUS_BAD},
        '{REQ_REMOVE_LAST, 6'd0,  32'h0000_0000, 1'b1, 32'h0, 7'd0, STATUS_BAD},
        '{REQ_ERASE,       6'd0,  32'h0000_0000, 1'b1, 32'h0, 7'd0, STATUS_BAD},
        '{REQ_WRITE,       6'd0,  32'h0000_0001, 1'b1, 32'h0, 7'd0, STATUS_BAD},
        '{REQ_INSERT,      6'd1,  32'h0000_0005, 1'b1, 32'h0, 7'd0, STATUS_BAD},
        // insert at the end of an empty list, then append, both value extremes
        '{REQ_INSERT,      6'd0,  32'h8000_0000, 1'b1, 32'h0, 7'd1, STATUS_OK},
        '{REQ_APPEND,      6'd63, 32'h7fff_ffff, 1'b1, 32'h0, 7'd2, STATUS_OK},
        '{REQ_READ,        6'd0,  32'hffff_ffff, 1'b1, 32'h8000_0000, 7'd2, STATUS_OK},
        '{REQ_READ,        6'd1,  32'h0000_0000, 1'b1, 32'h7fff_ffff, 7'd2, STATUS_OK},
        // insert in the middle and exactly at the end
        '{REQ_INSERT,      6'd1,  32'h0000_0000, 1'b0, 32'h0, 7'd0, STATUS_OK},
        '{REQ_INSERT,      6'd3,  32'hffff_ffff, 1'b0, 32'h0, 7'd0, STATUS_OK},
        // insert past the end
        '{REQ_INSERT,      6'd5,  32'h0000_0001, 1'b1, 32'h0, 7'd4, STATUS_BAD},
        '{REQ_WRITE,       6'd2,  32'h5555_5555, 1'b0, 32'h0, 7'd0, STATUS_OK},
        '{REQ_READ,        6'd2,  32'h0000_0000, 1'b0, 32'h0, 7'd0, STATUS_OK},
        '{REQ_WRITE,       6'd63, 32'haaaa_aaaa, 1'b1, 32'h0, 7'd4, STATUS_BAD},
        '{REQ_ERASE,       6'd0,  32'h0000_0000, 1'b0, 32'h0, 7'd0, STATUS_OK},
        '{REQ_ERASE,       6'd3,  32'h0000_0000, 1'b1, 32'h0, 7'd3, STATUS_BAD},
        // unknown request codes
        '{REQ_UNUSED_LO,   6'd0,  32'h0000_0000, 1'b1, 32'h0, 7'd3, STATUS_BAD},
        '{REQ_UNUSED_HI,   6'd63, 32'hffff_ffff, 1'b1, 32'h0, 7'd3, STATUS_BAD},
        '{REQ_REMOVE_LAST, 6'd0,  32'h0000_0000, 1'b0, 32'h0, 7'd0, STATUS_OK},
        '{REQ_READ,        6'd63, 32'h0000_0000, 1'b1, 32'h0, 7'd2, STATUS_BAD},
        '{REQ_READ,        6'd1,  32'h0000_0000, 1'b0, 32'h0, 7'd0, STATUS_OK},
        // erase the last element
        '{REQ_ERASE,       6'd1,  32'h0000_0000, 1'b0, 32'h0, 7'd0, STATUS_OK}
    };

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_beat_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_beat_t rsp;

    // predicted list contents and size
    logic signed [DATA_W-1:0] list_words [CAPACITY];
    int                       list_count;

    // result beats still owed by the core, oldest first
    rsp_beat_t awaited_results [$];

    // when set, neither side idles
    bit steady_phase;

    int mismatch_count;
    int cycle_count;
    int requests_sent;
    int results_checked;
    int full_hits;
    int bad_hits;
    int peak_count;

    indexed_list_insert_erase_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ERROR: run stopped after %0d cycles with %0d beats outstanding",
                     cycle_count, awaited_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("ERROR: rsp beat %0d field %s got %0h, predicted %0h",
                 results_checked, field, got, want);
        mismatch_count++;
    endtask

    // applies one request to the predicted list and returns the result beat it gives
    function automatic rsp_beat_t apply_list_request(input req_beat_t beat);
        rsp_beat_t  res;
        logic [2:0] code;
        int         pos;
        int         i;
        res.read_value = '0;
        res.status     = STATUS_OK;
        code = beat.req_type;
        pos  = beat.position;
        case (code)
            REQ_READ:
                if (pos < list_count)
                    res.read_value = list_words[pos];
                else
                    res.status = STATUS_BAD;
            REQ_WRITE:
                if (pos < list_count)
                    list_words[pos] = beat.element_value;
                else
                    res.status = STATUS_BAD;
            REQ_APPEND:
                if (list_count >= CAPACITY)
                    res.status = STATUS_FULL;
                else
                begin
                    list_words[list_count] = beat.element_value;
                    list_count++;
                end
            REQ_REMOVE_LAST:
                if (list_count == 0)
                    res.status = STATUS_BAD;
                else
                    list_count--;
            REQ_INSERT:
                // full is checked before the position
                if (list_count >= CAPACITY)
                    res.status = STATUS_FULL;
                else if (pos > list_count)
                    res.status = STATUS_BAD;
                else
                begin
                    for (i = list_count; i > pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos] = beat.element_value;
                    list_count++;
                end
            REQ_ERASE:
                if (pos >= list_count)
                    res.status = STATUS_BAD;
                else
                begin
                    for (i = pos; i + 1 < list_count; i++)
                        list_words[i] = list_words[i + 1];
                    list_count--;
                end
            default:
                res.status = STATUS_BAD;
        endcase
        res.element_count = 7'(list_count);
        return res;
    endfunction

    // random request shaped by the phase mix; positions mostly land inside the list
    function automatic req_beat_t draw_request(input phase_mix_t mix);
        req_beat_t  beat;
        logic [2:0] code;
        int         r;
        r = $urandom_range(0, 99);
        case (mix)
            PHASE_GROW:
                code = (r < 45) ? REQ_APPEND : (r < 85) ? REQ_INSERT :
                       (r < 92) ? REQ_READ : (r < 97) ? REQ_WRITE :
                       (r < 99) ? REQ_ERASE : REQ_REMOVE_LAST;
            PHASE_SHRINK:
                code = (r < 35) ? REQ_ERASE : (r < 65) ? REQ_REMOVE_LAST :
                       (r < 80) ? REQ_READ : (r < 90) ? REQ_WRITE :
                       (r < 96) ? REQ_INSERT : (r < 98) ? REQ_APPEND :
                       3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            default:
                code = (r < 20) ? REQ_READ : (r < 35) ? REQ_WRITE :
                       (r < 50) ? REQ_APPEND : (r < 60) ? REQ_REMOVE_LAST :
                       (r < 80) ? REQ_INSERT : (r < 97) ? REQ_ERASE :
                       3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        endcase
        beat.req_type = req_type_t'(code);
        if ($urandom_range(0, 99) < 15)
            beat.position = 6'($urandom_range(0, 63));
        else if (code == REQ_INSERT)
            beat.position = 6'($urandom_range(0, (list_count > 63) ? 63 : list_count));
        else
            beat.position = 6'($urandom_range(0, (list_count > 0) ? list_count - 1 : 0));
        case ($urandom_range(0, 19))
            0:       beat.element_value = 32'sh8000_0000;
            1:       beat.element_value = 32'sh7fff_ffff;
            2:       beat.element_value = '0;
            3:       beat.element_value = '1;
            default: beat.element_value = $urandom;
        endcase
        return beat;
    endfunction

    // drives one request beat from a falling edge and returns at the falling edge after
    // acceptance; the predicted or typed result is queued at the accepting edge
    task automatic send_request(input req_beat_t beat, input bit known,
                                input rsp_beat_t known_rsp);
        int        gap;
        rsp_beat_t predicted;
        gap = steady_phase ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= beat;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = apply_list_request(beat);
        awaited_results = {awaited_results, (known ? known_rsp : predicted)};
        requests_sent++;
        if (predicted.status == STATUS_FULL)
            full_hits++;
        if (predicted.status == STATUS_BAD)
            bad_hits++;
        if (list_count > peak_count)
            peak_count = list_count;
        @(negedge clk);
    endtask

    // holds the request side idle until every owed beat has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_results.size() != 0);
    endtask

    // result side: random stall before each beat, none in steady phases
    initial
    begin : rsp_driver
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = steady_phase ? 0 : $urandom_range(0, MAX_GAP);
            repeat (stall)
            begin
                rsp_ready <= 1'b0;
                @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_valid && rsp_ready));
            @(negedge clk);
        end
    end

    // every accepted result beat is checked against the oldest owed one
    always @(posedge clk)
    begin : rsp_check
        rsp_beat_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                // beat arrived with nothing owed
                flag_mismatch("beats returned", 32'(results_checked + 1),
                              32'(requests_sent));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp.read_value !== want.read_value)
                    flag_mismatch("read_value", rsp.read_value, want.read_value);
                if (rsp.element_count !== want.element_count)
                    flag_mismatch("element_count", 32'(rsp.element_count),
                                  32'(want.element_count));
                if (rsp.status !== want.status)
                    flag_mismatch("status", 32'(rsp.status), 32'(want.status));
            end
            results_checked++;
        end
    end

    // reset, directed table, random phases, drain and verdict
    initial
    begin : stimulus
        req_beat_t  beat;
        rsp_beat_t  known_rsp;
        phase_mix_t mix;
        int         random_sent;
        int         phase_idx;
        int         phase_len;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_ready    = 1'b0;
        steady_phase = 1'b0;
        list_count   = 0;
        random_sent  = 0;
        phase_idx    = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            beat.req_type          = req_type_t'(directed_rows[k].code);
            beat.position          = directed_rows[k].pos;
            beat.element_value     = directed_rows[k].value;
            known_rsp.read_value    = directed_rows[k].exp_value;
            known_rsp.element_count = directed_rows[k].exp_count;
            known_rsp.status        = directed_rows[k].exp_status;
            send_request(beat, directed_rows[k].known, known_rsp);
        end
        drain_results();

        // random phases: first a growing mix, then a shrinking one, then random mixes
        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase_idx == 0)
                mix = PHASE_GROW;
            else if (phase_idx == 1)
                mix = PHASE_SHRINK;
            else
                mix = phase_mix_t'($urandom_range(0, 2));
            phase_len    = $urandom_range(60, 140);
            steady_phase = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                send_request(draw_request(mix), 1'b0, known_rsp);
                random_sent++;
            end
            steady_phase = 1'b0;
            // after phase one and at random later, the sender holds off until the core has returned everything
            if (phase_idx == 0 || $urandom_range(0, 2) == 0)
                drain_results();
            phase_idx++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("ran %0d requests (%0d directed, %0d random in %0d phases), %0d beats checked",
                 requests_sent, DIRECTED_ROWS, random_sent, phase_idx, results_checked);
        $display("list peaked at %0d entries; %0d full and %0d rejected requests seen",
                 peak_count, full_hits, bad_hits);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/ilie_pkg.sv
hdl/ilie_cell.sv
hdl/ilie_ctrl.sv
hdl/indexed_list_insert_erase_core.sv
tb/tb_indexed_list_insert_erase_core.sv
